>>> src/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Types, field widths and codes shared by the round-robin scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int DEF_MAX_JOBS = 64;

    localparam int OPCODE_W = 2;
    localparam int LEN_W    = 16;
    localparam int JIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int JOB_ID_W = 6;
    localparam int TIME_W   = 22;
    localparam int SUM_W    = 28;
    localparam int FCNT_W   = 7;
    localparam int SLICE_W  = 16;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 184;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(4);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_RUN    = 2'd1,
        OP_REPORT = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_NO_JOB     = 3'd3,
        ST_UNFINISHED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RING = 4'b0010,
        S_EXEC = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] finish;
        logic [TIME_W-1:0] response;
        logic              finished;
        logic              started;
        logic [LEN_W-1:0]  remaining;
        logic [LEN_W-1:0]  length;
    } job_entry_t;

    typedef struct packed {
        logic [FCNT_W-1:0]   finished_count;
        logic [SUM_W-1:0]    sum_wait;
        logic [SUM_W-1:0]    sum_turnaround;
        logic [SUM_W-1:0]    sum_response;
        logic [TIME_W-1:0]   wait_time;
        logic [TIME_W-1:0]   turnaround_time;
        logic [TIME_W-1:0]   response_time;
        logic                job_done;
        logic [LEN_W-1:0]    run_amount;
        logic [JOB_ID_W-1:0] job_id;
        status_t             status;
    } result_t;

endpackage

>>> src/round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_scheduler
// Round-robin job scheduler with time quantum and per-job timing metrics.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An add or a clear goes from S_IDLE to
// S_FIN, a report passes S_EXEC first and a dispatch S_RING and S_EXEC: the
// dispatch reads the ready ring, then the job table, then writes the job
// back, S_FIN closes the sums, memory reads are registered. A full-table
// add, a dispatch on an empty ring and a report of an unknown job need no
// memory read and go straight to S_FIN. The block takes the
// next item as soon as the previous result sits in the output register,
// which holds until the downstream side takes it. Job state lives in two
// single-port-read memories (ready ring and job table) with no reset; every
// entry is written when a job is added, before any read of it.
// ----------------------------------------------------------------------------
module round_robin_scheduler #(
    parameter int MAX_JOBS = rrs_pkg::DEF_MAX_JOBS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: job_length[15:0], job_index[21:16], zero pad
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rrs_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [rrs_pkg::OPCODE_W-1:0]       s_tuser,
    // m_tdata: status, job_id, run_amount, job_done, response_time,
    // turnaround_time, wait_time, sum_response, sum_turnaround, sum_wait,
    // finished_count, zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rrs_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rrs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rrs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rrs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import rrs_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int CMP_W = (CNT_W > JIDX_W) ? CNT_W : JIDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_JOBS);
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    // memories
    logic [IDX_W-1:0] ring_mem [MAX_JOBS];
    job_entry_t       job_mem  [MAX_JOBS];

    logic             ring_we;
    logic [IDX_W-1:0] ring_waddr;
    logic [IDX_W-1:0] ring_wdata;
    logic [IDX_W-1:0] ring_raddr;
    logic [IDX_W-1:0] ring_q;
    logic             job_we;
    logic [IDX_W-1:0] job_waddr;
    job_entry_t       job_wdata;
    logic [IDX_W-1:0] job_raddr;
    job_entry_t       job_q;

    // control state
    state_t            state_reg, state_next;
    logic [SLICE_W-1:0] time_slice_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  next_id_reg, next_id_next;
    logic [TIME_W-1:0] cur_time_reg, cur_time_next;
    logic [SUM_W-1:0]  tot_resp_reg, tot_resp_next;
    logic [SUM_W-1:0]  tot_turn_reg, tot_turn_next;
    logic [SUM_W-1:0]  tot_wait_reg, tot_wait_next;
    logic [CNT_W-1:0]  done_cnt_reg, done_cnt_next;
    logic              m_valid_reg, m_valid_next;

    // item payload
    opcode_t           op_reg, op_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  jid_reg, jid_next;
    status_t           status_reg, status_next;
    logic [LEN_W-1:0]  run_reg, run_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] resp_reg, resp_next;
    logic [TIME_W-1:0] turn_reg, turn_next;
    result_t           out_reg, out_next;

    logic              s_fire;
    opcode_t           in_op;
    logic [LEN_W-1:0]  in_len;
    logic [JIDX_W-1:0] in_idx;
    logic [SLICE_W-1:0] slice;
    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] time_sat;
    logic [LEN_W-1:0]  run_amt;
    logic [TIME_W-1:0] len_ext;
    logic [TIME_W-1:0] wait_val;
    logic [SUM_W:0]    sr_sum, st_sum, sw_sum;
    logic              out_free;
    logic              cfg_wr;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign in_op    = opcode_t'(s_tuser);
    assign in_len   = s_tdata[LEN_W-1:0];
    assign in_idx   = s_tdata[LEN_W +: JIDX_W];
    assign out_free = ~m_valid_reg | m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? APB_DATA_W'(time_slice_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_slice_reg <= SLICE_RESET;
        end
        else if (cfg_wr)
        begin
            time_slice_reg <= pwdata[SLICE_W-1:0];
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_q <= ring_mem[ring_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (job_we)
        begin
            job_mem[job_waddr] <= job_wdata;
        end
        job_q <= job_mem[job_raddr];
    end

    // datapath helpers
    assign slice    = (time_slice_reg == '0) ? SLICE_W'(1) : time_slice_reg;
    assign run_amt  = (job_q.remaining > slice) ? slice : job_q.remaining;
    assign time_sum = {1'b0, cur_time_reg} + (TIME_W + 1)'(run_amt);
    assign time_sat = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
    assign len_ext  = TIME_W'(len_reg);
    assign wait_val = (done_reg && (turn_reg >= len_ext)) ? (turn_reg - len_ext) : '0;
    assign sr_sum   = {1'b0, tot_resp_reg} + (SUM_W + 1)'(resp_reg);
    assign st_sum   = {1'b0, tot_turn_reg} + (SUM_W + 1)'(turn_reg);
    assign sw_sum   = {1'b0, tot_wait_reg} + (SUM_W + 1)'(wait_val);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        cur_time_next = cur_time_reg;
        tot_resp_next = tot_resp_reg;
        tot_turn_next = tot_turn_reg;
        tot_wait_next = tot_wait_reg;
        done_cnt_next = done_cnt_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        op_next       = op_reg;
        len_next      = len_reg;
        jid_next      = jid_reg;
        status_next   = status_reg;
        run_next      = run_reg;
        done_next     = done_reg;
        resp_next     = resp_reg;
        turn_next     = turn_reg;
        out_next      = out_reg;

        ring_we    = 1'b0;
        ring_waddr = tail_reg;
        ring_wdata = jid_reg;
        ring_raddr = head_reg;
        job_we     = 1'b0;
        job_waddr  = jid_reg;
        job_wdata  = job_q;
        job_raddr  = ring_q;

        case (state_reg)
            S_IDLE:
            begin
                job_raddr = IDX_W'(in_idx);
                if (s_fire)
                begin
                    op_next     = in_op;
                    len_next    = in_len;
                    jid_next    = '0;
                    status_next = ST_OK;
                    run_next    = '0;
                    done_next   = 1'b0;
                    resp_next   = '0;
                    turn_next   = '0;
                    state_next  = S_FIN;
                    case (in_op)
                        OP_ADD:
                        begin
                            if (next_id_reg >= MAX_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                jid_next            = IDX_W'(next_id_reg);
                                job_we              = 1'b1;
                                job_waddr           = IDX_W'(next_id_reg);
                                job_wdata.length    = in_len;
                                job_wdata.remaining = in_len;
                                job_wdata.started   = 1'b0;
                                job_wdata.finished  = 1'b0;
                                job_wdata.response  = '0;
                                job_wdata.finish    = '0;
                                ring_we             = 1'b1;
                                ring_wdata          = IDX_W'(next_id_reg);
                                tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                                count_next   = count_reg + 1'b1;
                                next_id_next = next_id_reg + 1'b1;
                            end
                        end
                        OP_RUN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = S_RING;
                            end
                        end
                        OP_REPORT:
                        begin
                            if (CMP_W'(in_idx) >= CMP_W'(next_id_reg))
                            begin
                                status_next = ST_NO_JOB;
                            end
                            else
                            begin
                                jid_next   = IDX_W'(in_idx);
                                state_next = S_EXEC;
                            end
                        end
                        default:
                        begin
                            head_next     = '0;
                            tail_next     = '0;
                            count_next    = '0;
                            next_id_next  = '0;
                            cur_time_next = '0;
                            tot_resp_next = '0;
                            tot_turn_next = '0;
                            tot_wait_next = '0;
                            done_cnt_next = '0;
                        end
                    endcase
                end
            end
            S_RING:
            begin
                job_raddr  = ring_q;
                jid_next   = ring_q;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                len_next   = job_q.length;
                if (op_reg == OP_RUN)
                begin
                    job_we            = 1'b1;
                    job_waddr         = jid_reg;
                    job_wdata         = job_q;
                    job_wdata.started = 1'b1;
                    resp_next         = job_q.started ? job_q.response : cur_time_reg;
                    job_wdata.response = resp_next;
                    run_next          = run_amt;
                    cur_time_next     = time_sat;
                    if (job_q.remaining > slice)
                    begin
                        job_wdata.remaining = job_q.remaining - slice;
                        ring_we    = 1'b1;
                        ring_wdata = jid_reg;
                        tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        job_wdata.remaining = '0;
                        job_wdata.finished  = 1'b1;
                        job_wdata.finish    = time_sat;
                        done_next           = 1'b1;
                        turn_next           = time_sat;
                    end
                end
                else
                begin
                    resp_next = job_q.started ? job_q.response : '0;
                    if (job_q.finished)
                    begin
                        done_next = 1'b1;
                        turn_next = job_q.finish;
                    end
                    else
                    begin
                        status_next = ST_UNFINISHED;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if ((op_reg == OP_RUN) && done_reg)
                    begin
                        tot_resp_next = sr_sum[SUM_W] ? SUM_MAX : sr_sum[SUM_W-1:0];
                        tot_turn_next = st_sum[SUM_W] ? SUM_MAX : st_sum[SUM_W-1:0];
                        tot_wait_next = sw_sum[SUM_W] ? SUM_MAX : sw_sum[SUM_W-1:0];
                        done_cnt_next = done_cnt_reg + 1'b1;
                    end
                    out_next.status          = status_reg;
                    out_next.job_id          = JOB_ID_W'(jid_reg);
                    out_next.run_amount      = run_reg;
                    out_next.job_done        = done_reg;
                    out_next.response_time   = resp_reg;
                    out_next.turnaround_time = turn_reg;
                    out_next.wait_time       = wait_val;
                    out_next.sum_response    = tot_resp_next;
                    out_next.sum_turnaround  = tot_turn_next;
                    out_next.sum_wait        = tot_wait_next;
                    out_next.finished_count  = FCNT_W'(done_cnt_next);
                    m_valid_next             = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            next_id_reg  <= '0;
            cur_time_reg <= '0;
            tot_resp_reg <= '0;
            tot_turn_reg <= '0;
            tot_wait_reg <= '0;
            done_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            cur_time_reg <= cur_time_next;
            tot_resp_reg <= tot_resp_next;
            tot_turn_reg <= tot_turn_next;
            tot_wait_reg <= tot_wait_next;
            done_cnt_reg <= done_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        len_reg    <= len_next;
        jid_reg    <= jid_next;
        status_reg <= status_next;
        run_reg    <= run_next;
        done_reg   <= done_next;
        resp_reg   <= resp_next;
        turn_reg   <= turn_next;
        out_reg    <= out_next;
    end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for round_robin_scheduler. Jobs are added, dispatched,
// reported and cleared over the stream ports while the time slice is changed
// over APB between phases. A behavioural scheduler model predicts every
// result, and each result leaving the block is checked field by field against
// the oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrs_pkg::*;

    localparam int JOBS = DEF_MAX_JOBS;
    localparam int RANDOM_ITEMS = 260;
    localparam logic [APB_ADDR_W-1:0] REG_TIME_SLICE = APB_ADDR_W'(0);
    localparam logic [31:0] TIME_CAP = 32'd4194303;
    localparam logic [31:0] SUM_CAP  = 32'd268435455;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    round_robin_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // scheduler model state
    logic [SLICE_W-1:0]  slice_cfg = SLICE_RESET;
    logic [JOB_ID_W-1:0] ready_ring [JOBS];
    logic [5:0]          ring_rd;
    logic [5:0]          ring_wr;
    logic [6:0]          ring_cnt;
    logic [6:0]          next_id;
    logic [LEN_W-1:0]    job_len   [JOBS];
    logic [LEN_W-1:0]    job_left  [JOBS];
    logic                job_started  [JOBS];
    logic                job_finished [JOBS];
    logic [TIME_W-1:0]   job_resp [JOBS];
    logic [TIME_W-1:0]   job_fin  [JOBS];
    logic [TIME_W-1:0]   clock_now;
    logic [SUM_W-1:0]    tot_resp;
    logic [SUM_W-1:0]    tot_turn;
    logic [SUM_W-1:0]    tot_wait;
    logic [FCNT_W-1:0]   fin_cnt;

    result_t sched_expect [$];
    int      fail_count = 0;
    int      items_sent = 0;
    bit      no_idle = 1'b0;

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b, logic [31:0] lim);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[31:0];
    endfunction

    function automatic logic [TIME_W-1:0] wait_of_job(logic [JOB_ID_W-1:0] id);
        return (job_fin[id] >= job_len[id]) ? job_fin[id] - job_len[id] : '0;
    endfunction

    function automatic void clear_schedule();
        for (int i = 0; i < JOBS; i++) begin
            job_started[i]  = 1'b0;
            job_finished[i] = 1'b0;
        end
        ring_rd   = '0;
        ring_wr   = '0;
        ring_cnt  = '0;
        next_id   = '0;
        clock_now = '0;
        tot_resp  = '0;
        tot_turn  = '0;
        tot_wait  = '0;
        fin_cnt   = '0;
    endfunction

    function automatic result_t schedule_step(opcode_t op, logic [LEN_W-1:0] len,
                                              logic [JIDX_W-1:0] idx);
        result_t             r;
        logic [JOB_ID_W-1:0] id;
        logic [LEN_W-1:0]    quantum;
        r = '0;
        case (op)
            OP_ADD:
                if (next_id >= JOBS) r.status = ST_FULL;
                else
                begin
                    id = next_id[JOB_ID_W-1:0];
                    job_len[id]      = len;
                    job_left[id]     = len;
                    job_started[id]  = 1'b0;
                    job_finished[id] = 1'b0;
                    ready_ring[ring_wr] = id;
                    ring_wr++;
                    ring_cnt++;
                    next_id++;
                    r.job_id = id;
                end
            OP_RUN:
                if (ring_cnt == 0) r.status = ST_EMPTY;
                else
                begin
                    quantum = (slice_cfg == 0) ? LEN_W'(1) : slice_cfg;
                    id = ready_ring[ring_rd];
                    ring_rd++;
                    ring_cnt--;
                    if (!job_started[id])
                    begin
                        job_started[id] = 1'b1;
                        job_resp[id]    = clock_now;
                    end
                    r.job_id        = id;
                    r.response_time = job_resp[id];
                    if (job_left[id] > quantum)
                    begin
                        r.run_amount = quantum;
                        job_left[id] = job_left[id] - quantum;
                        clock_now = TIME_W'(sat_add(32'(clock_now), 32'(quantum), TIME_CAP));
                        ready_ring[ring_wr] = id;
                        ring_wr++;
                        ring_cnt++;
                    end
                    else
                    begin
                        r.run_amount = job_left[id];
                        clock_now = TIME_W'(sat_add(32'(clock_now), 32'(job_left[id]),
                                                    TIME_CAP));
                        job_left[id]     = '0;
                        job_fin[id]      = clock_now;
                        job_finished[id] = 1'b1;
                        r.job_done        = 1'b1;
                        r.turnaround_time = clock_now;
                        r.wait_time       = wait_of_job(id);
                        tot_resp = SUM_W'(sat_add(32'(tot_resp), 32'(r.response_time),
                                                  SUM_CAP));
                        tot_turn = SUM_W'(sat_add(32'(tot_turn), 32'(r.turnaround_time),
                                                  SUM_CAP));
                        tot_wait = SUM_W'(sat_add(32'(tot_wait), 32'(r.wait_time),
                                                  SUM_CAP));
                        fin_cnt++;
                    end
                end
            OP_REPORT:
                if (idx >= next_id) r.status = ST_NO_JOB;
                else
                begin
                    r.job_id = idx;
                    if (job_started[idx]) r.response_time = job_resp[idx];
                    if (job_finished[idx])
                    begin
                        r.job_done        = 1'b1;
                        r.turnaround_time = job_fin[idx];
                        r.wait_time       = wait_of_job(idx);
                    end
                    else r.status = ST_UNFINISHED;
                end
            default: clear_schedule();
        endcase
        if (op != OP_CLEAR)
        begin
            r.sum_response   = tot_resp;
            r.sum_turnaround = tot_turn;
            r.sum_wait       = tot_wait;
            r.finished_count = fin_cnt;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            fail_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
        end
    endtask

    task automatic check_result(logic [OUT_DATA_W-1:0] data);
        result_t got;
        result_t want;
        got = data[$bits(result_t)-1:0];
        if (sched_expect.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected result, expected none got %h", $time, data);
        end
        else
        begin
            want = sched_expect.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("job_id", 32'(want.job_id), 32'(got.job_id));
            check_field("run_amount", 32'(want.run_amount), 32'(got.run_amount));
            check_field("job_done", 32'(want.job_done), 32'(got.job_done));
            check_field("response_time", 32'(want.response_time),
                        32'(got.response_time));
            check_field("turnaround_time", 32'(want.turnaround_time),
                        32'(got.turnaround_time));
            check_field("wait_time", 32'(want.wait_time), 32'(got.wait_time));
            check_field("sum_response", 32'(want.sum_response), 32'(got.sum_response));
            check_field("sum_turnaround", 32'(want.sum_turnaround),
                        32'(got.sum_turnaround));
            check_field("sum_wait", 32'(want.sum_wait), 32'(got.sum_wait));
            check_field("finished_count", 32'(want.finished_count),
                        32'(got.finished_count));
        end
    endtask

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sched_expect.push_back(schedule_step(opcode_t'(s_tuser), s_tdata[15:0],
                                                 s_tdata[21:16]));
        if (m_tvalid && m_tready)
            check_result(m_tdata);
    end

    initial
    begin : downstream
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // leaves tvalid high so back-to-back transfers need no second assignment
    task automatic send_item(opcode_t op, logic [LEN_W-1:0] len, logic [JIDX_W-1:0] idx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, idx, len};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sched_expect.size() != 0) @(posedge clk);
    endtask

    task automatic write_slice(logic [SLICE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TIME_SLICE;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        slice_cfg = value;
        @(posedge clk);
    endtask

    function automatic int slices_for(logic [LEN_W-1:0] len);
        int q;
        q = (slice_cfg == 0) ? 1 : int'(slice_cfg);
        return (len == 0) ? 1 : (int'(len) + q - 1) / q;
    endfunction

    // reset slice of 4: empty ring, unknown job, zero length, requeue, clear
    task automatic test_basic_ops();
        send_item(OP_RUN, LEN_W'($urandom), JIDX_W'($urandom));
        send_item(OP_REPORT, LEN_W'($urandom), 6'd0);
        send_item(OP_ADD, 16'd0, JIDX_W'($urandom));
        send_item(OP_ADD, 16'd4, JIDX_W'($urandom));
        send_item(OP_ADD, 16'd9, JIDX_W'($urandom));
        send_item(OP_REPORT, LEN_W'($urandom), 6'd1);
        repeat (3) send_item(OP_RUN, LEN_W'($urandom), JIDX_W'($urandom));
        send_item(OP_REPORT, LEN_W'($urandom), 6'd2);
        repeat (3) send_item(OP_RUN, LEN_W'($urandom), JIDX_W'($urandom));
        for (int i = 0; i < 4; i++) send_item(OP_REPORT, LEN_W'($urandom), JIDX_W'(i));
        send_item(OP_REPORT, 16'hffff, 6'd63);
        send_item(OP_CLEAR, LEN_W'($urandom), JIDX_W'($urandom));
        send_item(OP_REPORT, LEN_W'($urandom), 6'd0);
    endtask

    // zero slice acts as one, then the widest slice with the longest jobs
    task automatic test_slice_extremes();
        drain_results();
        write_slice('0);
        send_item(OP_ADD, 16'd2, JIDX_W'($urandom));
        send_item(OP_ADD, 16'd1, JIDX_W'($urandom));
        repeat (4) send_item(OP_RUN, LEN_W'($urandom), JIDX_W'($urandom));
        drain_results();
        write_slice(16'hffff);
        send_item(OP_ADD, 16'hffff, 6'd63);
        send_item(OP_ADD, 16'hffff, 6'd0);
        repeat (2) send_item(OP_RUN, LEN_W'($urandom), JIDX_W'($urandom));
        send_item(OP_REPORT, LEN_W'($urandom), 6'd1);
        send_item(OP_CLEAR, LEN_W'($urandom), JIDX_W'($urandom));
    endtask

    // fill the job table, overflow it, then run every job to completion
    task automatic test_table_full();
        drain_results();
        no_idle = 1'b1;
        for (int i = 0; i < JOBS; i++)
            send_item(OP_ADD, 16'hffff - LEN_W'($urandom_range(0, 3)), JIDX_W'($urandom));
        no_idle = 1'b0;
        send_item(OP_ADD, LEN_W'($urandom), JIDX_W'($urandom));
        send_item(OP_REPORT, LEN_W'($urandom), 6'd63);
        for (int i = 0; i < JOBS + 1; i++)
        begin
            send_item(OP_RUN, LEN_W'($urandom), JIDX_W'($urandom));
            if ($urandom_range(0, 7) == 0)
                send_item(OP_REPORT, LEN_W'($urandom), JIDX_W'($urandom));
        end
        send_item(OP_REPORT, LEN_W'($urandom), 6'd63);
        send_item(OP_CLEAR, LEN_W'($urandom), JIDX_W'($urandom));
    endtask

    // well-formed job sets run to completion, with reports, late arrivals,
    // surplus dispatches and the odd clear that cuts a set short
    task automatic test_random_traffic();
        int               stop_at;
        int               added;
        int               pending;
        int               njobs;
        int               pick;
        logic [LEN_W-1:0] len;
        logic [SLICE_W-1:0] slice;
        stop_at = items_sent + RANDOM_ITEMS;
        added   = 0;
        while (items_sent < stop_at)
        begin
            drain_results();
            case ($urandom_range(0, 4))
                0: slice = '0;
                1: slice = 16'd1;
                2: slice = SLICE_W'($urandom_range(2, 16));
                3: slice = SLICE_W'($urandom);
                default: slice = 16'hffff;
            endcase
            write_slice(slice);
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0 || added > JOBS - 8)
            begin
                send_item(OP_CLEAR, LEN_W'($urandom), JIDX_W'($urandom));
                added = 0;
            end
            njobs = ($urandom_range(0, 7) == 0) ? $urandom_range(8, JOBS + 2)
                                                : $urandom_range(1, 10);
            pending = 0;
            repeat (njobs)
            begin
                len = LEN_W'($urandom_range(0, (slice == 0) ? 4 : 4 * int'(slice)));
                send_item(OP_ADD, len, JIDX_W'($urandom));
                if (added < JOBS)
                begin
                    added++;
                    pending += slices_for(len);
                end
            end
            pending += $urandom_range(0, 2);
            while (pending > 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                begin
                    send_item(OP_RUN, LEN_W'($urandom), JIDX_W'($urandom));
                    pending--;
                end
                else if (pick < 18)
                    send_item(OP_REPORT, LEN_W'($urandom),
                              (added > 0 && $urandom_range(0, 1)) ?
                              JIDX_W'($urandom_range(0, added - 1)) : JIDX_W'($urandom));
                else if (pick == 18)
                begin
                    len = LEN_W'($urandom_range(0, (slice == 0) ? 4 : 2 * int'(slice)));
                    send_item(OP_ADD, len, JIDX_W'($urandom));
                    if (added < JOBS)
                    begin
                        added++;
                        pending += slices_for(len);
                    end
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    send_item(OP_CLEAR, LEN_W'($urandom), JIDX_W'($urandom));
                    added = 0;
                    pending = 0;
                end
                else
                    send_item(OP_REPORT, LEN_W'($urandom),
                              JIDX_W'($urandom_range(added, 63)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        clear_schedule();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_ops();
        test_slice_extremes();
        test_table_full();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge clk);
        if (sched_expect.size() != 0)
        begin
            fail_count++;
            $display("%0t: results outstanding, expected 0 got %0d", $time,
                     sched_expect.size());
        end
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

>>> filelist.f
src/rrs_pkg.sv
src/round_robin_scheduler.sv
dv/tb.sv
